@@ src/hvn_pkg.sv @@
// Package for the heightmap vertex normal block: payload structs, sequencer and normalizer states
// and fixed constants. No dependencies.
`timescale 1ns / 1ps
package hvn_pkg;

   localparam int FRAC_BITS = 14;
   localparam int GUARD_BITS = 8;

   typedef struct packed {
      logic       operation;
      logic [7:0] x_coord;
      logic [7:0] z_coord;
      logic [7:0] height_byte;
   } req_type;

   typedef struct packed {
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
   } rsp_type;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_TRI,
      ST_NORM,
      ST_NWAIT,
      ST_SUM,
      ST_FNORM,
      ST_FWAIT,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      N_IDLE, N_SQ, N_SQRT, N_DIV, N_OUT
   } norm_state_type;

   typedef struct packed {
      logic        start;
      logic        guard;
      logic signed [19:0] vx;
      logic signed [19:0] vy;
      logic signed [19:0] vz;
   } norm_cmd_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
   } norm_sts_type;

endpackage

@@ src/hvn_norm.sv @@
// Shared iterative normalizer: squares, integer square root and a restoring
// divider, one bit per cycle. Depends on hvn_pkg.
`timescale 1ns / 1ps
module hvn_norm (
   input  logic                 clock,
   input  logic                 reset,
   input  hvn_pkg::norm_cmd_type cmd,
   output hvn_pkg::norm_sts_type sts
);

   hvn_pkg::norm_state_type st_ff, st_in;
   logic [1:0]         idx_ff, idx_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [19:0]        mag_ff [3];
   logic [2:0]         neg_ff;
   logic [57:0]        sum_ff, sum_in;
   logic [57:0]        rem_ff, rem_in;
   logic [29:0]        root_ff, root_in;
   logic [47:0]        dnum_ff, dnum_in;
   logic [31:0]        dq_ff, dq_in;
   logic [32:0]        drem_ff, drem_in;
   logic               guard_ff;
   logic [15:0]        res_ff [3];
   logic               done_ff;
   logic [39:0]        sq;
   logic [59:0]        trial;
   logic [59:0]        rem_sh;
   logic [32:0]        dtrial;
   logic [31:0]        den;
   logic [31:0]        mq;
   logic [15:0]        one_sat;
   logic [15:0]        fld;

   assign sq = mag_ff[idx_ff] * mag_ff[idx_ff];
   assign rem_sh = {rem_ff, 2'b00} | 60'(sum_ff >> (2 * cnt_ff)) & 60'd3;
   assign trial = {28'd0, root_ff, 2'b01};
   assign den = {1'b0, root_ff, 1'b0};
   assign dtrial = {drem_ff[31:0], dnum_ff[47]};
   assign mq = (dq_ff > 32'(1 << hvn_pkg::FRAC_BITS)) ? 32'(1 << hvn_pkg::FRAC_BITS) : dq_ff;
   assign one_sat = mq[15:0];
   assign fld = neg_ff[idx_ff] ? 16'(-$signed({1'b0, one_sat})) : one_sat;

   always_comb begin
      st_in = st_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      dnum_in = dnum_ff;
      dq_in = dq_ff;
      drem_in = drem_ff;
      case (st_ff)
         hvn_pkg::N_IDLE: begin
            if (cmd.start) begin
               st_in = hvn_pkg::N_SQ;
               idx_in = 2'd0;
               sum_in = '0;
            end
         end
         hvn_pkg::N_SQ: begin
            sum_in = sum_ff + 58'(sq);
            if (idx_ff == 2'd2) begin
               st_in = hvn_pkg::N_SQRT;
               cnt_in = 6'd28;
               rem_in = '0;
               root_in = '0;
               if (guard_ff) sum_in = (sum_ff + 58'(sq)) << (2 * hvn_pkg::GUARD_BITS);
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         hvn_pkg::N_SQRT: begin
            if (rem_sh >= trial) begin
               rem_in = 58'(rem_sh - trial);
               root_in = {root_ff[28:0], 1'b1};
            end else begin
               rem_in = 58'(rem_sh);
               root_in = {root_ff[28:0], 1'b0};
            end
            if (cnt_ff == 6'd0) begin
               st_in = hvn_pkg::N_DIV;
               idx_in = 2'd0;
               cnt_in = 6'd47;
               dq_in = '0;
               drem_in = '0;
               dnum_in = (48'(mag_ff[0]) << (hvn_pkg::FRAC_BITS + 1
                          + (guard_ff ? hvn_pkg::GUARD_BITS : 0)))
                         + 48'(root_in);
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         hvn_pkg::N_DIV: begin
            dnum_in = {dnum_ff[46:0], 1'b0};
            if (root_ff == '0) begin
               drem_in = dtrial;
               dq_in = {dq_ff[30:0], 1'b0};
            end else if (dtrial >= 33'(den)) begin
               drem_in = dtrial - 33'(den);
               dq_in = {dq_ff[30:0], 1'b1};
            end else begin
               drem_in = dtrial;
               dq_in = {dq_ff[30:0], 1'b0};
            end
            if (cnt_ff == 6'd0) st_in = hvn_pkg::N_OUT;
            else cnt_in = cnt_ff - 6'd1;
         end
         hvn_pkg::N_OUT: begin
            if (idx_ff == 2'd2) begin
               st_in = hvn_pkg::N_IDLE;
            end else begin
               idx_in = idx_ff + 2'd1;
               st_in = hvn_pkg::N_DIV;
               cnt_in = 6'd47;
               dq_in = '0;
               drem_in = '0;
               dnum_in = (48'(mag_ff[idx_ff + 2'd1]) << (hvn_pkg::FRAC_BITS + 1
                          + (guard_ff ? hvn_pkg::GUARD_BITS : 0)))
                         + 48'(root_ff);
            end
         end
         default: st_in = hvn_pkg::N_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= hvn_pkg::N_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         done_ff <= (st_ff == hvn_pkg::N_OUT) && (idx_ff == 2'd2);
      end
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      sum_ff <= sum_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      dnum_ff <= dnum_in;
      dq_ff <= dq_in;
      drem_ff <= drem_in;
      if (st_ff == hvn_pkg::N_IDLE && cmd.start) begin
         guard_ff <= cmd.guard;
         mag_ff[0] <= cmd.vx[19] ? 20'(-cmd.vx) : cmd.vx;
         mag_ff[1] <= cmd.vy[19] ? 20'(-cmd.vy) : cmd.vy;
         mag_ff[2] <= cmd.vz[19] ? 20'(-cmd.vz) : cmd.vz;
         neg_ff <= {cmd.vz[19], cmd.vy[19], cmd.vx[19]};
      end
      if (st_ff == hvn_pkg::N_OUT) res_ff[idx_ff] <= fld;
   end

   assign sts.busy = (st_ff != hvn_pkg::N_IDLE);
   assign sts.done = done_ff;
   assign sts.nx = res_ff[0];
   assign sts.ny = res_ff[1];
   assign sts.nz = res_ff[2];

   assert property (@(posedge clock) disable iff (reset)
      (st_ff == hvn_pkg::N_OUT && idx_ff == 2'd2) |=> sts.done)
      else $error("normalizer finished without done");
   assert property (@(posedge clock) disable iff (reset)
      sts.done |-> st_ff == hvn_pkg::N_IDLE)
      else $error("done while busy");
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == hvn_pkg::N_DIV) |-> cnt_ff <= 6'd47)
      else $error("divider count out of range");

endmodule

@@ src/hvn_seq.sv @@
// Query sequencer: reads the 3x3 neighborhood from the height memory, forms
// triangle normals, accumulates them and runs the final normalization. Uses hvn_pkg.
`timescale 1ns / 1ps
module hvn_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [7:0]            qx,
   input  logic [7:0]            qz,
   input  logic [8:0]            side,
   output logic [15:0]           rd_addr,
   input  logic [7:0]            rd_data,
   output hvn_pkg::norm_cmd_type ncmd,
   input  hvn_pkg::norm_sts_type nsts,
   output logic                  busy,
   output logic                  done,
   output hvn_pkg::rsp_type      result
);

   hvn_pkg::state_type st_ff, st_in;
   logic [3:0]  k_ff, k_in;
   logic [2:0]  t_ff, t_in;
   logic [7:0]  h_ff [9];
   logic [8:0]  hok_ff;
   logic signed [19:0] ax_ff, ay_ff, az_ff;
   logic signed [19:0] vx, vz;
   logic [8:0]  px, pz;
   logic [1:0]  kx, kz;
   logic [1:0]  cx, cz;
   logic        use_t;
   logic signed [9:0] a00, a10, a11, a01;
   logic [3:0]  rk_ff;

   always_comb begin
      case (k_ff) inside
         4'd0, 4'd3, 4'd6: kx = 2'd0;
         4'd1, 4'd4, 4'd7: kx = 2'd1;
         default: kx = 2'd2;
      endcase
      case (k_ff) inside
         [4'd0:4'd2]: kz = 2'd0;
         [4'd3:4'd5]: kz = 2'd1;
         default: kz = 2'd2;
      endcase
      px = {1'b0, qx} + {7'd0, kx} - 9'd1;
      pz = {1'b0, qz} + {7'd0, kz} - 9'd1;
   end
   assign rd_addr = {pz[7:0], px[7:0]};

   always_comb begin
      case (t_ff[2:1])
         2'd0: begin cx = 2'd0; cz = 2'd0; end
         2'd1: begin cx = 2'd0; cz = 2'd1; end
         2'd2: begin cx = 2'd1; cz = 2'd1; end
         default: begin cx = 2'd1; cz = 2'd0; end
      endcase
      case (t_ff)
         3'd0, 3'd1: use_t = (qx != 8'd0) && (qz != 8'd0);
         3'd2: use_t = (qx != 8'd0) && (9'(qz) < side - 9'd1);
         3'd3: use_t = 1'b0;
         3'd4, 3'd5: use_t = (9'(qx) < side - 9'd1) && (9'(qz) < side - 9'd1);
         3'd6: use_t = 1'b0;
         default: use_t = (9'(qx) < side - 9'd1) && (qz != 8'd0);
      endcase
      a00 = {2'b0, h_ff[4'(cz) * 4'd3 + 4'(cx)]};
      a10 = {2'b0, h_ff[4'(cz) * 4'd3 + 4'(cx) + 4'd1]};
      a11 = {2'b0, h_ff[4'(cz) * 4'd3 + 4'(cx) + 4'd4]};
      a01 = {2'b0, h_ff[4'(cz) * 4'd3 + 4'(cx) + 4'd3]};
      if (!t_ff[0]) begin
         vx = 20'(a10 - a00);
         vz = 20'(a11 - a10);
      end else begin
         vx = 20'(a11 - a01);
         vz = 20'(a01 - a00);
      end
   end

   always_comb begin
      st_in = st_ff;
      k_in = k_ff;
      t_in = t_ff;
      case (st_ff)
         hvn_pkg::ST_IDLE: if (start) begin
            st_in = hvn_pkg::ST_READ;
            k_in = 4'd0;
         end
         hvn_pkg::ST_READ: begin
            if (k_ff == 4'd8) begin
               st_in = hvn_pkg::ST_TRI;
               t_in = 3'd0;
            end
            k_in = k_ff + 4'd1;
         end
         hvn_pkg::ST_TRI: begin
            if (k_ff != 4'd10) k_in = k_ff + 4'd1;
            else if (use_t) st_in = hvn_pkg::ST_NWAIT;
            else if (t_ff == 3'd7) st_in = hvn_pkg::ST_FNORM;
            else t_in = t_ff + 3'd1;
         end
         hvn_pkg::ST_NWAIT: if (nsts.done) st_in = hvn_pkg::ST_SUM;
         hvn_pkg::ST_SUM: begin
            if (t_ff == 3'd7) st_in = hvn_pkg::ST_FNORM;
            else begin
               st_in = hvn_pkg::ST_TRI;
               t_in = t_ff + 3'd1;
            end
         end
         hvn_pkg::ST_FNORM: st_in = hvn_pkg::ST_FWAIT;
         hvn_pkg::ST_FWAIT: if (nsts.done) st_in = hvn_pkg::ST_DONE;
         hvn_pkg::ST_DONE: st_in = hvn_pkg::ST_IDLE;
         default: st_in = hvn_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ncmd = '0;
      if (st_ff == hvn_pkg::ST_TRI && k_ff == 4'd10 && use_t) begin
         ncmd.start = 1'b1;
         ncmd.guard = 1'b1;
         ncmd.vx = vx;
         ncmd.vy = -20'sd16;
         ncmd.vz = vz;
      end else if (st_ff == hvn_pkg::ST_FNORM) begin
         ncmd.start = 1'b1;
         ncmd.vx = ax_ff;
         ncmd.vy = ay_ff;
         ncmd.vz = az_ff;
      end
      busy = (st_ff != hvn_pkg::ST_IDLE);
      done = (st_ff == hvn_pkg::ST_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= hvn_pkg::ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
      k_ff <= k_in;
      t_ff <= t_in;
      rk_ff <= k_ff;
      if (st_ff == hvn_pkg::ST_IDLE) begin
         ax_ff <= '0;
         ay_ff <= '0;
         az_ff <= '0;
      end
      if ((st_ff == hvn_pkg::ST_READ || st_ff == hvn_pkg::ST_TRI) && k_ff >= 4'd1
          && k_ff <= 4'd9) begin
         h_ff[rk_ff] <= hok_ff[rk_ff] ? rd_data : 8'd0;
      end
      if (st_ff == hvn_pkg::ST_READ) hok_ff[k_ff] <= (px[8] == 1'b0) && (pz[8] == 1'b0);
      if (st_ff == hvn_pkg::ST_SUM) begin
         ax_ff <= ax_ff + 20'(nsts.nx);
         ay_ff <= ay_ff + 20'(nsts.ny);
         az_ff <= az_ff + 20'(nsts.nz);
      end
      if (st_ff == hvn_pkg::ST_FWAIT && nsts.done) begin
         result.normal_x <= nsts.nx;
         result.normal_y <= nsts.ny;
         result.normal_z <= nsts.nz;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      ncmd.start |-> !nsts.busy)
      else $error("normalizer started while busy");
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == hvn_pkg::ST_SUM) |-> $past(nsts.done))
      else $error("sum without normalizer result");
   assert property (@(posedge clock) disable iff (reset)
      done |=> !busy)
      else $error("sequencer did not return idle");

endmodule

@@ src/heightmap_vertex_normal.sv @@
// Top level: height memory, command intake, query sequencer and shared normalizer.
// Depends on hvn_pkg, hvn_norm and hvn_seq.
//
//   Port group   Dir   Contents
//   req_*        in    operation, coordinates, height byte (hvn_pkg::req_type)
//   rsp_*        out   unit normal x, y, z (hvn_pkg::rsp_type)
//   csr_*        in    grid side, 9 bits
//
// A write is accepted and the next transaction may follow at once. A query runs on the
// shared normalizer: 3 squares, 29 square-root steps and three 48-step divisions for
// each of two to seven normalizations. Reset clears control only; heights are
// undefined until written. req_ready is low while a query runs or a result waits.
`timescale 1ns / 1ps
module heightmap_vertex_normal (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hvn_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hvn_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [8:0]       csr_data
);

   logic [7:0]  mem [65536];
   logic [8:0]  side_ff;
   logic [8:0]  side;
   logic [7:0]  ex, ez;
   logic [7:0]  qx_ff, qz_ff;
   logic        start_ff;
   logic        rsp_valid_ff;
   logic [15:0] rd_addr;
   logic [7:0]  rd_data_ff;
   logic        sbusy, sdone;
   hvn_pkg::rsp_type      sres;
   hvn_pkg::norm_cmd_type ncmd;
   hvn_pkg::norm_sts_type nsts;
   logic        acc;

   assign side = (side_ff < 9'd4) ? 9'd4 : ((side_ff > 9'd256) ? 9'd256 : side_ff);
   assign ex = (9'(req_data.x_coord) >= side) ? 8'd0 : req_data.x_coord;
   assign ez = (9'(req_data.z_coord) >= side) ? 8'd0 : req_data.z_coord;
   assign req_ready = !sbusy && !start_ff && !rsp_valid_ff;
   assign acc = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= 9'd256;
         start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) side_ff <= csr_data;
         start_ff <= acc && (req_data.operation == hvn_pkg::OP_QUERY);
         if (sdone) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
      if (acc) begin
         qx_ff <= ex;
         qz_ff <= ez;
      end
   end

   always_ff @(posedge clock) begin
      if (acc && req_data.operation == hvn_pkg::OP_WRITE) mem[{ez, ex}] <= req_data.height_byte;
      rd_data_ff <= mem[rd_addr];
   end

   hvn_seq u_seq (
      .clock(clock), .reset(reset), .start(start_ff), .qx(qx_ff), .qz(qz_ff),
      .side(side), .rd_addr(rd_addr), .rd_data(rd_data_ff), .ncmd(ncmd),
      .nsts(nsts), .busy(sbusy), .done(sdone), .result(sres)
   );

   hvn_norm u_norm (.clock(clock), .reset(reset), .cmd(ncmd), .sts(nsts));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = sres;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped");
   assert property (@(posedge clock) disable iff (reset)
      sdone |-> !rsp_valid_ff)
      else $error("result overwritten");
   assert property (@(posedge clock) disable iff (reset)
      start_ff |-> !sbusy)
      else $error("query started while busy");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for heightmap_vertex_normal: directed table then random phases
// over several grid sides, checked against an in-bench fixed-point normal predictor.
// Depends on hvn_pkg and the heightmap_vertex_normal RTL.
`timescale 1ns / 1ps
module tb_top;

   localparam int WATCHDOG_LIMIT = 6000;

   typedef struct {
      hvn_pkg::req_type req;
      bit               typed;
      hvn_pkg::rsp_type normal;
   } step_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   hvn_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   hvn_pkg::rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [8:0] csr_data;

   logic [7:0] height_mem [65536];
   bit         height_known [65536];
   logic [8:0] side_reg;
   hvn_pkg::rsp_type normal_queue [$];
   int         error_count;
   int         idle_cycles;
   int         item_count;
   bit         quiet;

   heightmap_vertex_normal u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint unsigned abs_val(input longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint scale_comp(input longint v, input longint unsigned len,
                                         input int guard);
      longint unsigned m;
      m = 0;
      if (len != 0)
         m = (2 * (abs_val(v) << (hvn_pkg::FRAC_BITS + guard)) + len) / (2 * len);
      if (m > (64'd1 << hvn_pkg::FRAC_BITS)) m = 64'd1 << hvn_pkg::FRAC_BITS;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   task automatic unit_vector(input longint vx, input longint vy, input longint vz,
                              input int guard,
                              output longint nx, output longint ny, output longint nz);
      longint unsigned len;
      len = int_sqrt((abs_val(vx) * abs_val(vx) + abs_val(vy) * abs_val(vy)
                      + abs_val(vz) * abs_val(vz)) << (2 * guard));
      nx = scale_comp(vx, len, guard);
      ny = scale_comp(vy, len, guard);
      nz = scale_comp(vz, len, guard);
   endtask

   function automatic int grid_side();
      if (side_reg < 4) return 4;
      if (side_reg > 256) return 256;
      return side_reg;
   endfunction

   function automatic longint height_at(input int x, input int z);
      return longint'(height_mem[z * 256 + x]);
   endfunction

   task automatic add_triangle(input int cx, input int cz, input bit upper,
                               inout longint ax, inout longint ay, inout longint az);
      longint h00, h10, h11, h01, nx, ny, nz;
      h00 = height_at(cx, cz);
      h10 = height_at(cx + 1, cz);
      h11 = height_at(cx + 1, cz + 1);
      h01 = height_at(cx, cz + 1);
      if (!upper)
         unit_vector(h10 - h00, -16, h11 - h10, hvn_pkg::GUARD_BITS, nx, ny, nz);
      else
         unit_vector(h11 - h01, -16, h01 - h00, hvn_pkg::GUARD_BITS, nx, ny, nz);
      ax += nx;
      ay += ny;
      az += nz;
   endtask

   task automatic predict_vertex_normal(input hvn_pkg::req_type r, output bit has_normal,
                                        output hvn_pkg::rsp_type normal);
      int d, x, z;
      longint ax, ay, az, nx, ny, nz;
      d = grid_side();
      x = (r.x_coord >= d) ? 0 : r.x_coord;
      z = (r.z_coord >= d) ? 0 : r.z_coord;
      ax = 0;
      ay = 0;
      az = 0;
      has_normal = (r.operation == hvn_pkg::OP_QUERY);
      if (!has_normal) begin
         height_mem[z * 256 + x] = r.height_byte;
         height_known[z * 256 + x] = 1'b1;
      end else begin
         if (x > 0 && z > 0) begin
            add_triangle(x - 1, z - 1, 1'b0, ax, ay, az);
            add_triangle(x - 1, z - 1, 1'b1, ax, ay, az);
         end
         if (x > 0 && z < d - 1) add_triangle(x - 1, z, 1'b0, ax, ay, az);
         if (x < d - 1 && z < d - 1) begin
            add_triangle(x, z, 1'b0, ax, ay, az);
            add_triangle(x, z, 1'b1, ax, ay, az);
         end
         if (x < d - 1 && z > 0) add_triangle(x, z - 1, 1'b1, ax, ay, az);
         unit_vector(ax, ay, az, 0, nx, ny, nz);
         normal.normal_x = 16'(nx);
         normal.normal_y = 16'(ny);
         normal.normal_z = 16'(nz);
      end
   endtask

   task automatic send_item(input hvn_pkg::req_type r, input bit typed,
                            input hvn_pkg::rsp_type typed_normal);
      bit               has_normal;
      hvn_pkg::rsp_type normal;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      predict_vertex_normal(r, has_normal, normal);
      if (has_normal)
         normal_queue.insert(normal_queue.size(), typed ? typed_normal : normal);
      item_count++;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic send_plain(input hvn_pkg::req_type r);
      send_item(r, 1'b0, '0);
   endtask

   task automatic write_side(input logic [8:0] value);
      req_valid <= 1'b0;
      while (normal_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      side_reg = value;
      csr_valid <= 1'b0;
   endtask

   task automatic random_query(input int d);
      hvn_pkg::req_type r;
      int x, z, nxp, nzp;
      r.operation = hvn_pkg::OP_QUERY;
      r.height_byte = 8'($urandom);
      if ($urandom_range(0, 4) == 0) begin
         r.x_coord = 8'($urandom);
         r.z_coord = 8'($urandom);
      end else begin
         r.x_coord = 8'($urandom_range(0, d - 1));
         r.z_coord = 8'($urandom_range(0, d - 1));
      end
      x = (r.x_coord >= d) ? 0 : r.x_coord;
      z = (r.z_coord >= d) ? 0 : r.z_coord;
      for (int dz = -1; dz <= 1; dz++) begin
         for (int dx = -1; dx <= 1; dx++) begin
            nxp = x + dx;
            nzp = z + dz;
            if (nxp >= 0 && nzp >= 0 && nxp < d && nzp < d
                && !height_known[nzp * 256 + nxp])
               send_plain('{hvn_pkg::OP_WRITE, 8'(nxp), 8'(nzp), 8'($urandom)});
         end
      end
      send_plain(r);
   endtask

   initial begin
      step_row_type     rows [17];
      logic [8:0]       sides [8];
      int               d;
      hvn_pkg::req_type r;
      hvn_pkg::rsp_type flat;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      side_reg = 9'd256;
      error_count = 0;
      item_count = 0;
      quiet = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      flat = '{16'sd0, -16'sd16384, 16'sd0};
      rows = '{
         '{'{hvn_pkg::OP_WRITE, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
         '{'{hvn_pkg::OP_WRITE, 8'd1, 8'd0, 8'd0}, 1'b0, '0},
         '{'{hvn_pkg::OP_WRITE, 8'd0, 8'd1, 8'd0}, 1'b0, '0},
         '{'{hvn_pkg::OP_WRITE, 8'd1, 8'd1, 8'd0}, 1'b0, '0},
         '{'{hvn_pkg::OP_QUERY, 8'd0, 8'd0, 8'hff}, 1'b1, flat},
         '{'{hvn_pkg::OP_WRITE, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
         '{'{hvn_pkg::OP_WRITE, 8'd254, 8'd255, 8'd255}, 1'b0, '0},
         '{'{hvn_pkg::OP_WRITE, 8'd255, 8'd254, 8'd255}, 1'b0, '0},
         '{'{hvn_pkg::OP_WRITE, 8'd254, 8'd254, 8'd255}, 1'b0, '0},
         '{'{hvn_pkg::OP_QUERY, 8'd255, 8'd255, 8'd0}, 1'b1, flat},
         '{'{hvn_pkg::OP_WRITE, 8'd1, 8'd1, 8'd255}, 1'b0, '0},
         '{'{hvn_pkg::OP_QUERY, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
         '{'{hvn_pkg::OP_WRITE, 8'd0, 8'd0, 8'd255}, 1'b0, '0},
         '{'{hvn_pkg::OP_WRITE, 8'd1, 8'd1, 8'd0}, 1'b0, '0},
         '{'{hvn_pkg::OP_QUERY, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
         '{'{hvn_pkg::OP_WRITE, 8'd254, 8'd255, 8'd0}, 1'b0, '0},
         '{'{hvn_pkg::OP_QUERY, 8'd255, 8'd255, 8'd0}, 1'b0, '0}
      };

      write_side(9'd256);
      foreach (rows[i]) send_item(rows[i].req, rows[i].typed, rows[i].normal);

      sides = '{9'd4, 9'd3, 9'd0, 9'd511, 9'd17, 9'd255, 9'd100, 9'd256};
      sides[6] = 9'($urandom_range(5, 256));
      for (int p = 0; p < 8; p++) begin
         write_side(sides[p]);
         d = grid_side();
         quiet = (p == 7);
         while (item_count < 17 + 100 * (p + 1)) begin
            if ($urandom_range(0, 9) < 4) begin
               random_query(d);
            end else begin
               r.operation = hvn_pkg::OP_WRITE;
               r.x_coord = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(0, d - 1));
               r.z_coord = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(0, d - 1));
               r.height_byte = 8'($urandom);
               send_plain(r);
            end
         end
      end
      req_valid <= 1'b0;
      while (normal_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

   int stall_left;
   always @(posedge clock) begin
      hvn_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (normal_queue.size() == 0) begin
            $error("unexpected transaction on result channel");
            error_count++;
         end else begin
            want = normal_queue.pop_front();
            if (rsp_data.normal_x !== want.normal_x) begin
               $error("normal_x expected %0d actual %0d", want.normal_x, rsp_data.normal_x);
               error_count++;
            end
            if (rsp_data.normal_y !== want.normal_y) begin
               $error("normal_y expected %0d actual %0d", want.normal_y, rsp_data.normal_y);
               error_count++;
            end
            if (rsp_data.normal_z !== want.normal_z) begin
               $error("normal_z expected %0d actual %0d", want.normal_z, rsp_data.normal_z);
               error_count++;
            end
         end
      end
      if (reset) begin
         stall_left = 0;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= (stall_left == 0);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 18);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
